/* design/pea_pkg.sv */
// pea_pkg: shared types and constants of the page extent allocator.
// No dependencies.
package pea_pkg;
	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_NOFIT = 3'd1;
	localparam logic [2:0] ST_ABOVE = 3'd2;
	localparam logic [2:0] ST_FULL  = 3'd3;
	localparam logic [2:0] ST_ZERO  = 3'd4;

	localparam logic OP_FREE  = 1'b0;
	localparam logic OP_ALLOC = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD,
		S_CHK,
		S_FREE_DEC,
		S_AL_CHK,
		S_WR,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_DONE
	} state_t;
endpackage

/* design/page_extent_allocator_top.sv */
// Page extent allocator: address-ordered table of free page extents.
// Uses pea_pkg.
//
// Every request is handled by one sequencer around a single table memory
// (base and length side by side), one read and one write port with a
// registered read. A request scans the table one entry per S_RD/S_CHK pair
// and, when an entry is inserted or removed, moves the tail one entry per
// S_SHIFT_RD/S_SHIFT_WR pair. in_stall is high from acceptance until the
// result beat is taken. Zero-count requests go from S_RD straight to S_DONE.
// The low limit may be written only while idle. A stored base keeps one bit
// above FRAME_BITS, since an extent may end past the top frame and a low
// allocation can move its base there.
module page_extent_allocator_top #(
	parameter int MAX_EXTENTS = 64,
	parameter int FRAME_BITS  = 36
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [FRAME_BITS-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  operation,
	input  logic [FRAME_BITS-1:0] page_addr,
	input  logic [FRAME_BITS-1:0] page_count,
	input  logic                  from_low,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [2:0]            status,
	output logic [FRAME_BITS-1:0] alloc_page
);
	localparam int IW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
	localparam int CW = $clog2(MAX_EXTENTS + 1);
	localparam int FB = FRAME_BITS;
	localparam int BW = FB + 1;
	localparam int MW = BW + FB;
	localparam logic [FB-1:0] LOW_RESET = FB'(64'hFFFFFFFF >> 12);

	logic [MW-1:0]   mem [MAX_EXTENTS];
	logic [MW-1:0]   rd_q;
	logic            mem_we;
	logic [IW-1:0]   wa, ra;
	logic [MW-1:0]   wd;

	pea_pkg::state_t st_q, st_d;
	logic [FB-1:0] low_q, addr_q, cnt_q, page_q;
	logic [CW-1:0] count_q, idx_q;
	logic          alloc_q, low_dir_q;
	logic [2:0]    stat_q;
	// previous (lower) entry kept during a free scan
	logic [BW-1:0] pb_q;
	logic [FB-1:0] pl_q;
	logic          have_prev_q;
	// shift control: dir 1 insert (move up), 0 remove (move down)
	logic          sh_up_q;
	logic [CW-1:0] sh_end_q;
	logic [MW-1:0] hold_q;

	logic [BW-1:0] rb;
	logic [FB-1:0] rl;
	assign rb = rd_q[MW-1:FB];
	assign rl = rd_q[FB-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) mem[wa] <= wd;
		rd_q <= mem[ra];
	end

	// shared adder/compare
	logic [FB:0] sum_lo, sum_hi, sum_all;
	assign sum_lo  = {1'b0, pl_q} + {1'b0, cnt_q};
	assign sum_hi  = {1'b0, rl} + {1'b0, cnt_q};
	assign sum_all = sum_hi + {1'b0, pl_q};

	logic end_lo, end_hi, j_lo, j_hi;
	logic [FB+1:0] pe;
	logic [FB:0] ae;
	assign pe = {1'b0, pb_q} + {2'b0, pl_q};
	assign ae = {1'b0, addr_q} + {1'b0, cnt_q};
	assign end_lo = have_prev_q && pe == {2'b0, addr_q} && !sum_lo[FB];
	// current entry exists (index below count); a free scan stops on it once base > addr
	logic cur_ok;
	assign cur_ok = idx_q < count_q;
	assign end_hi = cur_ok && ae == rb;
	assign j_lo = end_lo;
	assign j_hi = end_hi && (end_lo ? !sum_all[FB] : !sum_hi[FB]);

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			pea_pkg::S_IDLE:     if (in_valid) st_d = pea_pkg::S_RD;
			pea_pkg::S_RD:       st_d = (cnt_q == '0) ? pea_pkg::S_DONE : pea_pkg::S_CHK;
			pea_pkg::S_CHK:      st_d = pea_pkg::S_RD;
			pea_pkg::S_FREE_DEC: st_d = pea_pkg::S_DONE;
			pea_pkg::S_AL_CHK:   st_d = pea_pkg::S_RD;
			pea_pkg::S_WR:       st_d = pea_pkg::S_DONE;
			pea_pkg::S_SHIFT_RD: st_d = pea_pkg::S_SHIFT_WR;
			pea_pkg::S_SHIFT_WR: st_d = pea_pkg::S_SHIFT_RD;
			pea_pkg::S_DONE:     if (!out_stall) st_d = pea_pkg::S_IDLE;
			default:             st_d = pea_pkg::S_IDLE;
		endcase
	end

	assign in_stall  = st_q != pea_pkg::S_IDLE;
	assign out_valid = st_q == pea_pkg::S_DONE;
	assign status    = stat_q;
	assign alloc_page = page_q;

	// read address: scan index, or shift source
	always_comb begin
		ra = idx_q[IW-1:0];
		if (st_q == pea_pkg::S_SHIFT_RD)
			ra = sh_up_q ? IW'(idx_q - CW'(1)) : IW'(idx_q + CW'(1));
	end

	// sequencer datapath; read issued in S_RD/S_SHIFT_RD, data valid next state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= pea_pkg::S_IDLE;
			count_q <= '0;
			low_q <= LOW_RESET;
			stat_q <= pea_pkg::ST_OK;
			page_q <= '0;
			mem_we <= 1'b0;
		end else begin
			mem_we <= 1'b0;
			if (cfg_we) low_q <= cfg_wdata;
			unique case (st_q)
				pea_pkg::S_IDLE: begin
					st_q <= st_d;
					alloc_q <= operation;
					addr_q <= page_addr;
					cnt_q <= page_count;
					low_dir_q <= from_low;
					have_prev_q <= 1'b0;
					page_q <= '0;
					stat_q <= pea_pkg::ST_ZERO;
					idx_q <= (operation == pea_pkg::OP_ALLOC && !from_low)
						? count_q - CW'(1) : '0;
				end
				pea_pkg::S_RD: st_q <= st_d;
				pea_pkg::S_CHK: begin
					st_q <= st_d;
					if (alloc_q == pea_pkg::OP_ALLOC) begin
						// idx wraps to all ones past bottom for high search
						if (!cur_ok) begin
							stat_q <= pea_pkg::ST_NOFIT;
							st_q <= pea_pkg::S_DONE;
						end else if (rl >= cnt_q) begin
							if (low_dir_q && rb > {1'b0, low_q}) begin
								stat_q <= pea_pkg::ST_ABOVE;
								st_q <= pea_pkg::S_DONE;
							end else begin
								stat_q <= pea_pkg::ST_OK;
								page_q <= low_dir_q ? rb[FB-1:0]
									: rb[FB-1:0] + rl - cnt_q;
								st_q <= pea_pkg::S_WR;
								wa <= idx_q[IW-1:0];
								wd <= low_dir_q ? {rb + {1'b0, cnt_q}, rl - cnt_q}
									: {rb, rl - cnt_q};
								if (rl == cnt_q) begin
									sh_up_q <= 1'b0;
									sh_end_q <= count_q - CW'(1);
									st_q <= pea_pkg::S_SHIFT_RD;
									count_q <= count_q - CW'(1);
								end else mem_we <= 1'b1;
							end
						end else
							idx_q <= low_dir_q ? idx_q + CW'(1) : idx_q - CW'(1);
					end else if (cur_ok && rb <= {1'b0, addr_q}) begin
						have_prev_q <= 1'b1;
						pb_q <= rb;
						pl_q <= rl;
						idx_q <= idx_q + CW'(1);
					end else begin
						stat_q <= pea_pkg::ST_OK;
						if (j_lo && j_hi) begin
							wa <= IW'(idx_q - CW'(1));
							wd <= {pb_q, sum_all[FB-1:0]};
							mem_we <= 1'b1;
							sh_up_q <= 1'b0;
							sh_end_q <= count_q - CW'(1);
							count_q <= count_q - CW'(1);
							st_q <= pea_pkg::S_SHIFT_RD;
						end else if (j_lo) begin
							wa <= IW'(idx_q - CW'(1));
							wd <= {pb_q, sum_lo[FB-1:0]};
							mem_we <= 1'b1;
							st_q <= pea_pkg::S_DONE;
						end else if (j_hi) begin
							wa <= idx_q[IW-1:0];
							wd <= {1'b0, addr_q, sum_hi[FB-1:0]};
							mem_we <= 1'b1;
							st_q <= pea_pkg::S_DONE;
						end else if (count_q >= CW'(MAX_EXTENTS)) begin
							stat_q <= pea_pkg::ST_FULL;
							st_q <= pea_pkg::S_DONE;
						end else begin
							// insert: move tail up from the top, then write new
							hold_q <= {1'b0, addr_q, cnt_q};
							sh_up_q <= 1'b1;
							sh_end_q <= idx_q;
							idx_q <= count_q;
							count_q <= count_q + CW'(1);
							st_q <= pea_pkg::S_SHIFT_RD;
						end
					end
				end
				pea_pkg::S_WR: st_q <= st_d;
				pea_pkg::S_SHIFT_RD: begin
					if (idx_q == sh_end_q) begin
						if (sh_up_q) begin
							wa <= idx_q[IW-1:0];
							wd <= hold_q;
							mem_we <= 1'b1;
						end
						st_q <= pea_pkg::S_DONE;
					end else st_q <= st_d;
				end
				pea_pkg::S_SHIFT_WR: begin
					wa <= idx_q[IW-1:0];
					wd <= rd_q;
					mem_we <= 1'b1;
					idx_q <= sh_up_q ? idx_q - CW'(1) : idx_q + CW'(1);
					st_q <= st_d;
				end
				pea_pkg::S_DONE: begin
					if (stat_q != pea_pkg::ST_OK) page_q <= '0;
					st_q <= st_d;
				end
				default: st_q <= st_d;
			endcase
		end
	end
endmodule

/* design/pea_checker.sv */
// pea_checker: port-level assertions for page_extent_allocator_top.
// Bound to the top level; uses pea_pkg for status codes.
module pea_checker #(
	parameter int FRAME_BITS = 36
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [2:0]            status,
	input logic [FRAME_BITS-1:0] alloc_page
);
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= pea_pkg::ST_ZERO)
		else $error("status code out of range");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != pea_pkg::ST_OK |-> alloc_page == '0)
		else $error("page nonzero on failure");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status))
		else $error("stalled result changed");
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not closed after accepted beat");
endmodule

bind page_extent_allocator_top pea_checker #(.FRAME_BITS(FRAME_BITS)) u_pea_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .status(status),
	.alloc_page(alloc_page)
);

/* test/tb_top.sv */
// Testbench of page_extent_allocator_top: directed and random free/alloc beats,
// checked against a table-based predictor held in a small scoreboard class.
// Depends on pea_pkg and the RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NEXT = 64;
	localparam int FB = 36;
	localparam int BW = FB + 1;
	localparam logic [FB-1:0] FMASK = {FB{1'b1}};
	localparam int WATCHDOG = 20000;

	typedef struct {
		logic [2:0]    st;
		logic [FB-1:0] page;
	} alloc_result_t;

	class extent_scoreboard;
		// a base may pass the top frame after a low allocation
		logic [BW-1:0] base_q[$];
		logic [FB-1:0] len_q[$];
		logic [FB-1:0] low_limit;
		alloc_result_t pending[$];
		int mismatches;
		int checked;
		int n_ok, n_fail;

		function void clear();
			base_q.delete();
			len_q.delete();
			low_limit = 36'hFFFFF;
			pending.delete();
			mismatches = 0;
			checked = 0;
		endfunction

		function logic [2:0] apply_free(logic [FB-1:0] a, logic [FB-1:0] c);
			int pos;
			bit jlo, jhi;
			logic [FB:0] tot;
			pos = 0;
			jlo = 0;
			jhi = 0;
			while (pos < base_q.size() && base_q[pos] <= BW'(a))
				pos++;
			if (pos > 0 && (base_q[pos-1] + BW'(len_q[pos-1])) == BW'(a)
					&& ({1'b0, len_q[pos-1]} + {1'b0, c}) <= {1'b0, FMASK})
				jlo = 1;
			if (pos < base_q.size() && (BW'(a) + BW'(c)) == base_q[pos]) begin
				tot = {1'b0, c} + {1'b0, len_q[pos]};
				if (jlo)
					tot = tot + {1'b0, len_q[pos-1]};
				if (tot <= {1'b0, FMASK})
					jhi = 1;
			end
			if (jlo && jhi) begin
				len_q[pos-1] = len_q[pos-1] + c + len_q[pos];
				base_q.delete(pos);
				len_q.delete(pos);
			end else if (jlo) begin
				len_q[pos-1] = len_q[pos-1] + c;
			end else if (jhi) begin
				base_q[pos] = BW'(a);
				len_q[pos] = len_q[pos] + c;
			end else begin
				if (base_q.size() >= NEXT)
					return pea_pkg::ST_FULL;
				base_q.insert(pos, BW'(a));
				len_q.insert(pos, c);
			end
			return pea_pkg::ST_OK;
		endfunction

		function alloc_result_t apply_alloc(logic [FB-1:0] c, bit lo);
			alloc_result_t r;
			r.st = pea_pkg::ST_NOFIT;
			r.page = '0;
			if (lo) begin
				for (int i = 0; i < base_q.size(); i++) begin
					if (len_q[i] >= c) begin
						if (base_q[i] > BW'(low_limit)) begin
							r.st = pea_pkg::ST_ABOVE;
							return r;
						end
						r.st = pea_pkg::ST_OK;
						r.page = base_q[i][FB-1:0];
						base_q[i] = base_q[i] + BW'(c);
						len_q[i] = len_q[i] - c;
						if (len_q[i] == 0) begin
							base_q.delete(i);
							len_q.delete(i);
						end
						return r;
					end
				end
			end else begin
				for (int k = base_q.size() - 1; k >= 0; k--) begin
					if (len_q[k] >= c) begin
						len_q[k] = len_q[k] - c;
						r.st = pea_pkg::ST_OK;
						r.page = base_q[k][FB-1:0] + len_q[k];
						if (len_q[k] == 0) begin
							base_q.delete(k);
							len_q.delete(k);
						end
						return r;
					end
				end
			end
			return r;
		endfunction

		function void note_request(logic op, logic [FB-1:0] a, logic [FB-1:0] c, logic lo);
			alloc_result_t r;
			r.st = pea_pkg::ST_OK;
			r.page = '0;
			if (c == 0)
				r.st = pea_pkg::ST_ZERO;
			else if (op == pea_pkg::OP_ALLOC)
				r = apply_alloc(c, lo);
			else
				r.st = apply_free(a, c);
			if (r.st != pea_pkg::ST_OK)
				r.page = '0;
			if (r.st == pea_pkg::ST_OK) n_ok++; else n_fail++;
			pending.push_back(r);
		endfunction

		function void check_result(logic [2:0] st, logic [FB-1:0] page);
			alloc_result_t e;
			checked++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: status %0d page %h", st, page);
				return;
			end
			e = pending.pop_front();
			if (st !== e.st || page !== e.page) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch #%0d: status exp %0d got %0d, page exp %h got %h",
						checked, e.st, st, e.page, page);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [FB-1:0] cfg_wdata = '0;
	logic in_valid = 0;
	logic in_stall;
	logic operation = 0;
	logic [FB-1:0] page_addr = '0;
	logic [FB-1:0] page_count = '0;
	logic from_low = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [2:0] status;
	logic [FB-1:0] alloc_page;

	extent_scoreboard sb;
	int accepted = 0;
	int idle_cycles = 0;
	bit stall_mode_long = 0;
	int gap_max = 3;
	logic [FB-1:0] next_addr;

	always #5 clk = ~clk;

	page_extent_allocator_top #(.MAX_EXTENTS(NEXT), .FRAME_BITS(FB)) dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .operation(operation),
		.page_addr(page_addr), .page_count(page_count), .from_low(from_low),
		.out_valid(out_valid), .out_stall(out_stall), .status(status),
		.alloc_page(alloc_page)
	);

	// scoreboard hooks and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_request(operation, page_addr, page_count, from_low);
			if (out_valid && !out_stall)
				sb.check_result(status, alloc_page);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles > WATCHDOG) begin
				$display("watchdog expired, %0d results outstanding", sb.pending.size());
				$display("** page_extent_allocator_top: FAILED **");
				$finish;
			end
		end
	end

	// receiver stall pattern, with one long hold-off whenever stall_mode_long is set
	initial begin
		int hold;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_mode_long) begin
				hold = 600;
				out_stall <= 1;
				repeat (hold) @(posedge clk);
				stall_mode_long = 0;
				out_stall <= 0;
			end else begin
				out_stall <= ($urandom_range(0, 3) == 0) && ($urandom_range(0, 7) != 0);
			end
		end
	end

	// stall is looked at mid-cycle, where it is stable up to the next edge
	task automatic send_beat(logic op, logic [FB-1:0] a, logic [FB-1:0] c, logic lo);
		operation <= op;
		page_addr <= a;
		page_count <= c;
		from_low <= lo;
		in_valid <= 1;
		@(negedge clk);
		while (in_stall)
			@(negedge clk);
		@(posedge clk);
		accepted++;
	endtask

	// sender bursts: drops valid only between bursts
	int burst_left = 0;
	task automatic send_item(logic op, logic [FB-1:0] a, logic [FB-1:0] c, logic lo);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = $urandom_range(0, gap_max);
			if (gap > 0) begin
				in_valid <= 0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		send_beat(op, a, c, lo);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_low_limit(logic [FB-1:0] v);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		sb.low_limit = v;
		@(posedge clk);
	endtask

	function automatic logic [FB-1:0] rnd36();
		return {4'($urandom_range(0, 15)), $urandom()};
	endfunction

	function automatic logic [FB-1:0] rnd_count();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return rnd36();
			2, 3: return FB'($urandom_range(1, 4096));
			default: return FB'($urandom_range(1, 16));
		endcase
	endfunction

	// well-formed traffic: frees near a moving cursor, allocations that often fit
	task automatic random_phase(int n);
		logic [FB-1:0] a, c;
		for (int i = 0; i < n; i++) begin
			c = rnd_count();
			if ($urandom_range(0, 1)) begin
				case ($urandom_range(0, 5))
					0: a = rnd36();
					1: a = FMASK - FB'($urandom_range(0, 64));
					default: begin
						a = next_addr;
						next_addr = next_addr + c
							+ FB'(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8));
					end
				endcase
				if (sb.base_q.size() > 0 && $urandom_range(0, 6) == 0)
					a = sb.base_q[$urandom_range(0, sb.base_q.size() - 1)][FB-1:0];
				send_item(pea_pkg::OP_FREE, a, c, 1'($urandom_range(0, 1)));
			end else begin
				send_item(pea_pkg::OP_ALLOC, rnd36(), c, 1'($urandom_range(0, 1)));
			end
		end
	endtask

	initial begin
		sb = new();
		sb.clear();
		sb.n_ok = 0;
		sb.n_fail = 0;
		next_addr = 36'h100;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: zero counts, empty table, merges, limit, extremes
		send_beat(pea_pkg::OP_FREE, 36'h10, 0, 0);
		send_beat(pea_pkg::OP_ALLOC, 0, 0, 1);
		send_beat(pea_pkg::OP_ALLOC, 0, 1, 1);
		send_beat(pea_pkg::OP_ALLOC, 0, 1, 0);
		send_beat(pea_pkg::OP_FREE, 36'h100, 16, 0);
		send_beat(pea_pkg::OP_FREE, 36'h120, 16, 0);
		send_beat(pea_pkg::OP_FREE, 36'h110, 16, 0);
		send_beat(pea_pkg::OP_FREE, 36'h100, 4, 1);
		send_beat(pea_pkg::OP_ALLOC, 0, 8, 1);
		send_beat(pea_pkg::OP_ALLOC, 0, 8, 0);
		send_beat(pea_pkg::OP_FREE, 36'h200000, 32, 0);
		send_beat(pea_pkg::OP_ALLOC, 0, 100, 1);
		send_beat(pea_pkg::OP_ALLOC, 0, 100, 0);
		send_beat(pea_pkg::OP_FREE, FMASK, 1, 0);
		send_beat(pea_pkg::OP_FREE, 0, FMASK, 0);
		send_beat(pea_pkg::OP_FREE, FMASK - 3, 3, 0);
		send_beat(pea_pkg::OP_ALLOC, FMASK, FMASK, 1);
		send_beat(pea_pkg::OP_ALLOC, 0, FMASK, 0);
		send_beat(pea_pkg::OP_ALLOC, 0, 1, 1);
		drain();
		write_low_limit('0);
		send_beat(pea_pkg::OP_ALLOC, 0, 2, 1);
		send_beat(pea_pkg::OP_ALLOC, 0, 2, 0);
		drain();
		write_low_limit(FMASK);
		send_beat(pea_pkg::OP_ALLOC, 0, 4, 1);

		// fill the table with isolated extents past the full case, then merge onto one
		for (int i = 0; i < NEXT + 4; i++)
			send_item(pea_pkg::OP_FREE, 36'h8000_0000 + FB'(i * 4), 1, 0);
		send_item(pea_pkg::OP_FREE, 36'h8000_0000 + 1, 1, 0);

		// long receiver hold-off while the sender keeps offering
		stall_mode_long = 1;
		random_phase(40);
		drain();

		write_low_limit(36'hFFFFF);
		gap_max = 0;
		random_phase(600);
		drain();
		write_low_limit(FB'($urandom_range(0, 4096)));
		gap_max = 6;
		random_phase(700);
		drain();
		write_low_limit(rnd36());
		gap_max = 3;
		random_phase(650);
		drain();

		$display("covered %0d request beats: %0d succeeded, %0d refused",
			accepted, sb.n_ok, sb.n_fail);
		$display("%0d result beats checked, %0d mismatches", sb.checked, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("** page_extent_allocator_top: PASSED **");
		else
			$display("** page_extent_allocator_top: FAILED **");
		$finish;
	end
endmodule

/* sim.f */
design/pea_pkg.sv
design/page_extent_allocator_top.sv
design/pea_checker.sv
test/tb_top.sv
